>>> hdl/cft_pkg.sv
// Package for the CSV field tokenizer: parse state type, character codes
// and the per-item result struct shared by the decoder and the top level.
// No dependencies.
package cft_pkg;

    typedef enum logic [2:0] {
        ST_ENTRY  = 3'd0,
        ST_QUOTED = 3'd1,
        ST_BARE   = 3'd2,
        ST_EXIT   = 3'd3,
        ST_TRAIL  = 3'd4
    } t_parse_state;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [7:0] field_byte;
        logic       byte_valid;
        logic       field_end;
        logic       record_end;
        logic       err_set;
    } t_cft_result;

endpackage

>>> hdl/cft_decode.sv
// Combinational byte decoder of the CSV field tokenizer: from the current
// parse state, the input byte and the trailing-space enable it gives the next
// state and the result of the item. Depends on cft_pkg.
module cft_decode
    import cft_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_byte,
    input  logic         i_allow_trailing_space,
    output t_parse_state o_next_state,
    output t_cft_result  o_result
);

    always_comb begin
        o_next_state = i_state;
        case (i_state)
            ST_QUOTED: begin
                if (i_byte == CH_QUOTE) begin
                    o_next_state = ST_EXIT;
                end else if (i_byte == CH_NUL) begin
                    o_next_state = ST_ENTRY;
                end
            end
            ST_BARE: begin
                if (i_byte inside {CH_COMMA, CH_NUL}) begin
                    o_next_state = ST_ENTRY;
                end
            end
            ST_EXIT: begin
                if (i_byte == CH_QUOTE) begin
                    o_next_state = ST_QUOTED;
                end else if (i_byte inside {CH_COMMA, CH_NUL}) begin
                    o_next_state = ST_ENTRY;
                end else if (i_byte == CH_SPACE && i_allow_trailing_space) begin
                    o_next_state = ST_TRAIL;
                end else begin
                    o_next_state = ST_BARE;
                end
            end
            ST_TRAIL: begin
                if (i_byte inside {CH_COMMA, CH_NUL}) begin
                    o_next_state = ST_ENTRY;
                end else if (i_byte != CH_SPACE) begin
                    o_next_state = ST_BARE;
                end
            end
            default: begin
                if (i_byte == CH_QUOTE) begin
                    o_next_state = ST_QUOTED;
                end else if (i_byte inside {CH_COMMA, CH_NUL, CH_LF, CH_CR}) begin
                    o_next_state = ST_ENTRY;
                end else begin
                    o_next_state = ST_BARE;
                end
            end
        endcase
    end

    always_comb begin
        o_result = '0;
        case (i_state)
            ST_QUOTED: begin
                if (i_byte == CH_NUL) begin
                    // An unterminated quote at the end of a record is an error,
                    // but the record still closes normally.
                    o_result.err_set    = 1'b1;
                    o_result.field_end  = 1'b1;
                    o_result.record_end = 1'b1;
                end else if (i_byte != CH_QUOTE) begin
                    o_result.field_byte = i_byte;
                    o_result.byte_valid = 1'b1;
                end
            end
            ST_BARE: begin
                if (i_byte == CH_COMMA) begin
                    o_result.field_end = 1'b1;
                end else if (i_byte == CH_NUL) begin
                    o_result.field_end  = 1'b1;
                    o_result.record_end = 1'b1;
                end else if (!(i_byte inside {CH_LF, CH_CR})) begin
                    o_result.field_byte = i_byte;
                    o_result.byte_valid = 1'b1;
                end
            end
            ST_EXIT: begin
                if (i_byte == CH_QUOTE) begin
                    o_result.field_byte = CH_QUOTE;
                    o_result.byte_valid = 1'b1;
                end else if (i_byte == CH_COMMA) begin
                    o_result.field_end = 1'b1;
                end else if (i_byte == CH_NUL) begin
                    o_result.field_end  = 1'b1;
                    o_result.record_end = 1'b1;
                end else if (i_byte == CH_SPACE && i_allow_trailing_space) begin
                    o_result.field_end = 1'b1;
                end else begin
                    o_result.err_set = 1'b1;
                end
            end
            ST_TRAIL: begin
                // The field already ended at the first space, so a comma
                // here only returns to the entry state.
                if (i_byte == CH_NUL) begin
                    o_result.record_end = 1'b1;
                end else if (!(i_byte inside {CH_COMMA, CH_SPACE})) begin
                    o_result.err_set = 1'b1;
                end
            end
            default: begin
                if (i_byte == CH_COMMA) begin
                    o_result.field_end = 1'b1;
                end else if (i_byte == CH_NUL) begin
                    o_result.field_end  = 1'b1;
                    o_result.record_end = 1'b1;
                end else if (!(i_byte inside {CH_QUOTE, CH_LF, CH_CR})) begin
                    o_result.field_byte = i_byte;
                    o_result.byte_valid = 1'b1;
                end
            end
        endcase
    end

endmodule

>>> hdl/csv_field_tokenizer.sv
// Top level of the CSV field tokenizer: parse state, sticky error, the
// trailing-space register and the output register. Depends on cft_pkg and
// cft_decode.
//
// Usage:
//   Input channel: one byte per item on i_in_byte, qualified by i_valid and
//   held off by o_stall. A NUL byte ends the current record.
//   Output channel: one result item per input item (o_field_byte,
//   o_byte_valid, o_field_end, o_record_end, o_parse_error) with o_valid,
//   held off by i_stall.
//   Configuration: i_allow_trailing_space is written when i_cfg_valid and
//   o_cfg_ready are both high; o_cfg_ready is always high. Write it only
//   while no item is in flight.
//   The result of a byte accepted at one edge is registered and is on the
//   outputs after that edge. One byte is taken in every cycle unless o_stall
//   is high; the single output register sets that rate, and it refills at
//   the same edge at which its item is taken.
//   While the receiver stalls, the output item holds and o_stall is raised
//   as long as the output register is full.
//   Reset (synchronous, active low) returns to the entry state, clears the
//   error flag and the trailing-space enable and empties the output.
module csv_field_tokenizer
    import cft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_field_byte,
    output logic       o_byte_valid,
    output logic       o_field_end,
    output logic       o_record_end,
    output logic       o_parse_error,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_allow_trailing_space
);

    t_parse_state r_state;
    t_parse_state n_state;
    logic         r_err;
    logic         r_allow;
    logic         r_out_valid;
    t_cft_result  n_result;
    t_cft_result  r_result;
    logic         w_in_accept;

    cft_decode u_decode (
        .i_state                (r_state),
        .i_byte                 (i_in_byte),
        .i_allow_trailing_space (r_allow),
        .o_next_state           (n_state),
        .o_result               (n_result)
    );

    assign o_stall     = r_out_valid && i_stall;
    assign w_in_accept = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ENTRY;
            r_err       <= 1'b0;
            r_allow     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_allow <= i_allow_trailing_space;
            end
            if (w_in_accept) begin
                r_state     <= n_state;
                r_err       <= r_err | n_result.err_set;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_field_byte  = r_result.field_byte;
    assign o_byte_valid  = r_result.byte_valid;
    assign o_field_end   = r_result.field_end;
    assign o_record_end  = r_result.record_end;
    // The error register already holds the value after the item on the output.
    assign o_parse_error = r_err;

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("parse error flag cleared without reset");

    a_byte_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_valid) |-> (!o_field_end && !o_record_end))
        else $error("content byte given together with a field or record end");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> (o_field_byte == 8'h00))
        else $error("field byte not zero without a content byte");

    a_quoted_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_state == ST_QUOTED) |-> !o_field_end)
        else $error("field end given while a quoted field is open");

endmodule
